// File: rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg - shared types and constants for the IR frame decoder
// Transfer structs, register indexes, status codes and frame geometry.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int FRAME_SYMBOLS = 34;
    localparam int FIELD_BITS    = 16;
    localparam int IDX_W         = 6;
    localparam int TICK_W        = 15;
    localparam int CFG_IDX_W     = 3;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    // register reset values
    localparam logic             RST_INVERT       = 1'b0;
    localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 15'd9000;
    localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 15'd4500;
    localparam logic [TICK_W-1:0] RST_ZERO_MARK    = 15'd560;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;
    localparam logic [TICK_W-1:0] RST_ONE_MARK     = 15'd560;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;
    localparam logic [TICK_W-1:0] RST_TOLERANCE    = 15'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INVERT       = 3'd0,
        REG_LEADER_MARK  = 3'd1,
        REG_LEADER_SPACE = 3'd2,
        REG_ZERO_MARK    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_ONE_MARK     = 3'd5,
        REG_ONE_SPACE    = 3'd6,
        REG_TOLERANCE    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_WRONG_LENGTH = 2'd2
    } t_status;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_duration;
        logic              second_level;
        logic [TICK_W-1:0] second_duration;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        t_status               frame_status;
        logic [FIELD_BITS-1:0] device_address;
        logic [FIELD_BITS-1:0] key_command;
    } t_out_item;

endpackage

// File: rtl/ir_pulse_distance_frame_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder - pulse-distance IR frame decoder
// Checks captured symbols against leader and bit windows and reports one
// 16-bit address and 16-bit command per frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -----------------------
//  in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//  cfg       input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
//  One symbol per cycle. A symbol is latched in the input register; while it
//  is held, the window compares update the frame state and, on the frame's
//  last symbol, load the result register. The input register only stalls
//  when it holds a frame end while the result register is still full and
//  not being read out; the decode step waits with it.
//  Synchronous active-low reset clears the frame state, both valid flags and
//  restores the register defaults.
//
module ir_pulse_distance_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  irpd_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output irpd_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [irpd_pkg::TICK_W-1:0]     i_cfg_data
);

    localparam int PAY_W = 2 * irpd_pkg::FIELD_BITS;
    localparam int BIT_W = $clog2(PAY_W);

    // Strictly inside target +/- tolerance; a tolerance above the target
    // closes the window entirely.
    function automatic logic in_win(
        input logic [irpd_pkg::TICK_W-1:0] ticks,
        input logic [irpd_pkg::TICK_W-1:0] tgt,
        input logic [irpd_pkg::TICK_W-1:0] tol
    );
        logic [irpd_pkg::TICK_W:0] lo;
        logic [irpd_pkg::TICK_W:0] hi;
        lo = {1'b0, tgt} - {1'b0, tol};
        hi = {1'b0, tgt} + {1'b0, tol};
        return (tol <= tgt) && ({1'b0, ticks} > lo) && ({1'b0, ticks} < hi);
    endfunction

    // configuration registers
    logic                          r_invert;
    logic [irpd_pkg::TICK_W-1:0]   r_leader_mark;
    logic [irpd_pkg::TICK_W-1:0]   r_leader_space;
    logic [irpd_pkg::TICK_W-1:0]   r_zero_mark;
    logic [irpd_pkg::TICK_W-1:0]   r_zero_space;
    logic [irpd_pkg::TICK_W-1:0]   r_one_mark;
    logic [irpd_pkg::TICK_W-1:0]   r_one_space;
    logic [irpd_pkg::TICK_W-1:0]   r_tol;

    // input register
    logic                          r_in_vld;
    irpd_pkg::t_in_item            r_in;

    // frame state
    logic [irpd_pkg::IDX_W-1:0]    r_idx;
    logic                          r_leader_ok;
    logic [PAY_W-1:0]              r_pay;
    logic [irpd_pkg::IDX_W-1:0]    n_idx;
    logic                          n_leader_ok;
    logic [PAY_W-1:0]              n_pay;

    // result register
    logic                          r_out_vld;
    irpd_pkg::t_out_item           r_out;
    irpd_pkg::t_out_item           n_out;

    logic                          levels_ok;
    logic                          fit_leader;
    logic                          fit_zero;
    logic                          fit_one;
    logic                          step;
    logic                          emit;
    logic [irpd_pkg::IDX_W-1:0]    bit_off;
    logic [BIT_W-1:0]              bit_pos;

    // Step the held symbol unless it ends a frame and the result slot is
    // still occupied and not being read out.
    assign step = r_in_vld && (!r_in.frame_end || !r_out_vld || i_out_ready);
    assign emit = step && r_in.frame_end;

    assign o_in_ready  = !r_in_vld || step;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign levels_ok  = (r_in.first_level == r_invert) && (r_in.second_level != r_invert);
    assign fit_leader = levels_ok && in_win(r_in.first_duration, r_leader_mark, r_tol)
                                  && in_win(r_in.second_duration, r_leader_space, r_tol);
    assign fit_zero   = levels_ok && in_win(r_in.first_duration, r_zero_mark, r_tol)
                                  && in_win(r_in.second_duration, r_zero_space, r_tol);
    assign fit_one    = levels_ok && in_win(r_in.first_duration, r_one_mark, r_tol)
                                  && in_win(r_in.second_duration, r_one_space, r_tol);

    // symbol 1 lands in the top payload bit, MSB first
    assign bit_off = irpd_pkg::IDX_W'(PAY_W) - r_idx;
    assign bit_pos = bit_off[BIT_W-1:0];

    always_comb begin
        n_idx       = r_idx;
        n_leader_ok = r_leader_ok;
        n_pay       = r_pay;
        n_out       = r_out;
        if (step) begin
            if (r_idx == '0) begin
                n_leader_ok = fit_leader;
            end else if (r_idx <= irpd_pkg::IDX_W'(PAY_W)) begin
                // zero takes priority; a symbol fitting neither reads as zero
                if (!fit_zero && fit_one) begin
                    n_pay[bit_pos] = 1'b1;
                end
            end
            if (r_idx != irpd_pkg::IDX_MAX) begin
                n_idx = r_idx + irpd_pkg::IDX_W'(1);
            end
            if (r_in.frame_end) begin
                if (r_idx != irpd_pkg::IDX_W'(irpd_pkg::FRAME_SYMBOLS - 1)) begin
                    n_out.frame_status   = irpd_pkg::ST_WRONG_LENGTH;
                    n_out.device_address = '0;
                    n_out.key_command    = '0;
                end else if (!n_leader_ok) begin
                    n_out.frame_status   = irpd_pkg::ST_BAD_HEADER;
                    n_out.device_address = '0;
                    n_out.key_command    = '0;
                end else begin
                    n_out.frame_status   = irpd_pkg::ST_OK;
                    n_out.device_address = n_pay[PAY_W-1:irpd_pkg::FIELD_BITS];
                    n_out.key_command    = n_pay[irpd_pkg::FIELD_BITS-1:0];
                end
                n_idx       = '0;
                n_leader_ok = 1'b0;
                n_pay       = '0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert       <= irpd_pkg::RST_INVERT;
            r_leader_mark  <= irpd_pkg::RST_LEADER_MARK;
            r_leader_space <= irpd_pkg::RST_LEADER_SPACE;
            r_zero_mark    <= irpd_pkg::RST_ZERO_MARK;
            r_zero_space   <= irpd_pkg::RST_ZERO_SPACE;
            r_one_mark     <= irpd_pkg::RST_ONE_MARK;
            r_one_space    <= irpd_pkg::RST_ONE_SPACE;
            r_tol          <= irpd_pkg::RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (irpd_pkg::t_cfg_reg'(i_cfg_idx))
                irpd_pkg::REG_INVERT:       r_invert       <= i_cfg_data[0];
                irpd_pkg::REG_LEADER_MARK:  r_leader_mark  <= i_cfg_data;
                irpd_pkg::REG_LEADER_SPACE: r_leader_space <= i_cfg_data;
                irpd_pkg::REG_ZERO_MARK:    r_zero_mark    <= i_cfg_data;
                irpd_pkg::REG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                irpd_pkg::REG_ONE_MARK:     r_one_mark     <= i_cfg_data;
                irpd_pkg::REG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                default:                    r_tol          <= i_cfg_data;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_idx       <= '0;
            r_leader_ok <= 1'b0;
            r_pay       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            r_idx       <= n_idx;
            r_leader_ok <= n_leader_ok;
            r_pay       <= n_pay;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        r_out <= n_out;
    end

    // ---- assertions ----
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_idx == '0) && !r_leader_ok && (r_pay == '0))
        else $error("frame state not cleared after frame end");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.frame_status != irpd_pkg::ST_OK))
            |-> (r_out.device_address == '0) && (r_out.key_command == '0))
        else $error("non-zero fields on a rejected frame");

    a_stall_holds_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !step) |=> r_in_vld && $stable(r_in) && $stable(r_idx))
        else $error("held symbol or frame state changed during stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_vld && r_in.frame_end && r_out_vld && !i_out_ready)
        else $error("input stalled without a pending result");

endmodule

// File: tb/ir_pulse_distance_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_tb - self-checking bench for the IR decoder
// Walks a short table of hand-picked symbols, then streams random frames,
// mostly well formed, under six register settings and three idling mixes.
// Every frame result is checked against a local decoder model in order.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_tb;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int PHASE_SYMBOLS  = 280;   // symbol transfers per setting
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // pipeline is two deep
    localparam int PLAN_LEN       = 20;
    localparam int N_SETTINGS     = 6;

    // kinds of symbol the stimulus builds
    typedef enum {SYM_LEADER, SYM_ZERO, SYM_ONE, SYM_JUNK} t_sym_kind;

    // one register setting of the decoder
    typedef struct {
        logic                        inv;
        logic [irpd_pkg::TICK_W-1:0] lead_mark;
        logic [irpd_pkg::TICK_W-1:0] lead_space;
        logic [irpd_pkg::TICK_W-1:0] zero_mark;
        logic [irpd_pkg::TICK_W-1:0] zero_space;
        logic [irpd_pkg::TICK_W-1:0] one_mark;
        logic [irpd_pkg::TICK_W-1:0] one_space;
        logic [irpd_pkg::TICK_W-1:0] tol;
    } t_setting;

    // directed row: 'fixed' rows carry a hand-typed result, the rest are predicted
    typedef struct {
        irpd_pkg::t_in_item  sym;
        bit                  fixed;
        irpd_pkg::t_out_item want;
    } t_row;

    localparam irpd_pkg::t_out_item WRONG_LEN = '{irpd_pkg::ST_WRONG_LENGTH, 16'd0, 16'd0};
    localparam irpd_pkg::t_out_item NO_FRAME  = '0;

    // ------------------------------------------------------------------------
    // DUT signals; the inputs driven by the bench are known from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    irpd_pkg::t_in_item             i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    irpd_pkg::t_out_item            o_out_data;
    logic                           i_cfg_we    = 1'b0;
    logic [irpd_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [irpd_pkg::TICK_W-1:0]    i_cfg_data  = '0;

    ir_pulse_distance_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    irpd_pkg::t_out_item frames_due[$]; // decoded frames still owed by the DUT, oldest first
    int        fault_count  = 0;
    int        cycle_count  = 0;
    int        symbols_sent = 0;
    int        tx_idle_pct  = 0;  // sender idle chance per cycle, percent
    int        rx_idle_pct  = 0;  // receiver idle chance per cycle, percent
    int        hold_token   = 0;  // bumped by the stimulus to ask for a long hold-off

    // decoder model: registers and frame state, as after reset
    t_setting cfg_now = '{irpd_pkg::RST_INVERT, irpd_pkg::RST_LEADER_MARK,
                          irpd_pkg::RST_LEADER_SPACE, irpd_pkg::RST_ZERO_MARK,
                          irpd_pkg::RST_ZERO_SPACE, irpd_pkg::RST_ONE_MARK,
                          irpd_pkg::RST_ONE_SPACE, irpd_pkg::RST_TOLERANCE};
    logic [irpd_pkg::IDX_W-1:0]        frame_idx   = '0;
    bit                                hdr_seen    = 1'b0;
    logic [2*irpd_pkg::FIELD_BITS-1:0] payload_acc = '0;

    // settings walked by the random part; the first is the reset state, not written
    t_setting phase_cfg [N_SETTINGS] = '{
        '{1'b0, 15'd9000,  15'd4500,  15'd560,   15'd560, 15'd560,   15'd1690,  15'd200},
        '{1'b1, 15'd300,   15'd150,   15'd20,    15'd20,  15'd20,    15'd60,    15'd8},
        // margin at full scale: only the full-scale targets can match, zero never does
        '{1'b0, 15'd32767, 15'd32767, 15'd32767, 15'd100, 15'd32767, 15'd32767, 15'd32767},
        // margin equal to every mark target
        '{1'b0, 15'd10,    15'd10,    15'd10,    15'd30,  15'd10,    15'd50,    15'd10},
        // all zero: no window can match
        '{1'b1, 15'd0,     15'd0,     15'd0,     15'd0,   15'd0,     15'd0,     15'd0},
        // narrowest live window: exact target only
        '{1'b0, 15'd9000,  15'd4500,  15'd560,   15'd560, 15'd560,   15'd1690,  15'd1}
    };

    // directed symbols, reset register values assumed
    t_row plan [PLAN_LEN] = '{
        '{'{1'b0, 15'd0,     1'b0, 15'd0,     1'b1}, 1'b1, WRONG_LEN},  // all zero, lone
        '{'{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b1}, 1'b1, WRONG_LEN},  // all ones, lone
        '{'{1'b0, 15'd32767, 1'b0, 15'd0,     1'b1}, 1'b1, WRONG_LEN},
        '{'{1'b1, 15'd0,     1'b1, 15'd32767, 1'b1}, 1'b1, WRONG_LEN},
        '{'{1'b0, 15'd9000,  1'b1, 15'd4500,  1'b1}, 1'b1, WRONG_LEN},  // good leader, lone
        '{'{1'b0, 15'd8801,  1'b1, 15'd4699,  1'b0}, 1'b0, NO_FRAME},   // leader near edges
        '{'{1'b0, 15'd560,   1'b1, 15'd1690,  1'b0}, 1'b0, NO_FRAME},   // one
        '{'{1'b0, 15'd560,   1'b1, 15'd560,   1'b0}, 1'b0, NO_FRAME},   // zero
        '{'{1'b0, 15'd1000,  1'b1, 15'd1000,  1'b0}, 1'b0, NO_FRAME},   // neither bit
        '{'{1'b0, 15'd760,   1'b1, 15'd1890,  1'b0}, 1'b0, NO_FRAME},   // upper bound, out
        '{'{1'b0, 15'd361,   1'b1, 15'd1491,  1'b0}, 1'b0, NO_FRAME},   // lower bound, in
        '{'{1'b0, 15'd360,   1'b1, 15'd1490,  1'b0}, 1'b0, NO_FRAME},   // lower bound, out
        '{'{1'b1, 15'd560,   1'b0, 15'd1690,  1'b0}, 1'b0, NO_FRAME},   // levels swapped
        '{'{1'b0, 15'd560,   1'b0, 15'd1690,  1'b0}, 1'b0, NO_FRAME},   // levels equal
        '{'{1'b0, 15'd759,   1'b1, 15'd1889,  1'b1}, 1'b1, WRONG_LEN},  // short frame ends
        '{'{1'b0, 15'd9200,  1'b1, 15'd4500,  1'b0}, 1'b0, NO_FRAME},   // leader just out
        '{'{1'b0, 15'd32767, 1'b1, 15'd32767, 1'b0}, 1'b0, NO_FRAME},
        '{'{1'b1, 15'd0,     1'b0, 15'd0,     1'b1}, 1'b1, WRONG_LEN},
        '{'{1'b0, 15'd9199,  1'b1, 15'd4301,  1'b0}, 1'b0, NO_FRAME},
        '{'{1'b0, 15'd559,   1'b1, 15'd1691,  1'b1}, 1'b1, WRONG_LEN}
    };

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    // strict window around a target; a margin above the target never matches
    function automatic bit in_window(input logic [irpd_pkg::TICK_W-1:0] ticks,
                                     input logic [irpd_pkg::TICK_W-1:0] target);
        int unsigned t   = target;
        int unsigned tol = cfg_now.tol;
        int unsigned d   = ticks;
        if (tol > t)
            return 1'b0;
        return d > t - tol && d < t + tol;
    endfunction

    function automatic bit symbol_fits(input irpd_pkg::t_in_item sym,
                                       input logic [irpd_pkg::TICK_W-1:0] mark,
                                       input logic [irpd_pkg::TICK_W-1:0] space);
        return sym.first_level == cfg_now.inv && sym.second_level != cfg_now.inv &&
               in_window(sym.first_duration, mark) && in_window(sym.second_duration, space);
    endfunction

    // advance the frame by one symbol; returns 1 when the symbol closes a frame
    function automatic bit decode_symbol(input irpd_pkg::t_in_item sym,
                                         output irpd_pkg::t_out_item res);
        int unsigned pos = frame_idx;
        res = NO_FRAME;
        if (pos == 0) begin
            hdr_seen = symbol_fits(sym, cfg_now.lead_mark, cfg_now.lead_space);
        end else if (pos <= 2 * irpd_pkg::FIELD_BITS) begin
            // zero is tried first; a symbol matching neither stays a zero
            if (!symbol_fits(sym, cfg_now.zero_mark, cfg_now.zero_space) &&
                symbol_fits(sym, cfg_now.one_mark, cfg_now.one_space))
                payload_acc[2 * irpd_pkg::FIELD_BITS - pos] = 1'b1;
        end
        if (frame_idx != irpd_pkg::IDX_MAX)
            frame_idx = frame_idx + irpd_pkg::IDX_W'(1);
        if (!sym.frame_end)
            return 1'b0;
        // a wrong count wins over a bad header
        if (pos != irpd_pkg::FRAME_SYMBOLS - 1) begin
            res.frame_status = irpd_pkg::ST_WRONG_LENGTH;
        end else if (!hdr_seen) begin
            res.frame_status = irpd_pkg::ST_BAD_HEADER;
        end else begin
            res.frame_status   = irpd_pkg::ST_OK;
            res.device_address = payload_acc[2*irpd_pkg::FIELD_BITS-1:irpd_pkg::FIELD_BITS];
            res.key_command    = payload_acc[irpd_pkg::FIELD_BITS-1:0];
        end
        frame_idx   = '0;
        hdr_seen    = 1'b0;
        payload_acc = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Symbol construction
    // ------------------------------------------------------------------------
    // a duration inside the live window, or anything if the window is dead
    function automatic logic [irpd_pkg::TICK_W-1:0] near_target(
        input logic [irpd_pkg::TICK_W-1:0] target
    );
        int unsigned t   = target;
        int unsigned tol = cfg_now.tol;
        int unsigned hi;
        if (tol > t)
            return irpd_pkg::TICK_W'($urandom_range(0, 32767));
        if (tol == 0)
            return target;
        hi = t + tol - 1;
        if (hi > 32767)
            hi = 32767;
        return irpd_pkg::TICK_W'($urandom_range(hi, t - tol + 1));
    endfunction

    // a duration sitting exactly on one of the exclusive bounds, the upper one clamped to full scale
    function automatic logic [irpd_pkg::TICK_W-1:0] window_edge(
        input logic [irpd_pkg::TICK_W-1:0] target
    );
        int unsigned t   = target;
        int unsigned tol = cfg_now.tol;
        if (tol <= t && $urandom_range(0, 1))
            return irpd_pkg::TICK_W'(t - tol);
        return (t + tol > 32767) ? irpd_pkg::TICK_W'(32767) : irpd_pkg::TICK_W'(t + tol);
    endfunction

    function automatic irpd_pkg::t_in_item make_symbol(input t_sym_kind kind, input bit last);
        irpd_pkg::t_in_item          s;
        logic [irpd_pkg::TICK_W-1:0] mark;
        logic [irpd_pkg::TICK_W-1:0] space;
        s.frame_end = last;
        if (kind == SYM_JUNK) begin
            s.first_level     = 1'($urandom_range(0, 1));
            s.first_duration  = irpd_pkg::TICK_W'($urandom_range(0, 32767));
            s.second_level    = 1'($urandom_range(0, 1));
            s.second_duration = irpd_pkg::TICK_W'($urandom_range(0, 32767));
            return s;
        end
        case (kind)
            SYM_LEADER: begin
                mark  = cfg_now.lead_mark;
                space = cfg_now.lead_space;
            end
            SYM_ZERO: begin
                mark  = cfg_now.zero_mark;
                space = cfg_now.zero_space;
            end
            default: begin
                mark  = cfg_now.one_mark;
                space = cfg_now.one_space;
            end
        endcase
        s.first_level     = cfg_now.inv;
        s.second_level    = ~cfg_now.inv;
        s.first_duration  = near_target(mark);
        s.second_duration = near_target(space);
        // occasional damage so that bits and headers also fail
        case ($urandom_range(0, 39))
            0: s.first_level     = ~s.first_level;
            1: s.second_level    = ~s.second_level;
            2: s.first_duration  = window_edge(mark);
            3: s.second_duration = window_edge(space);
            4: s.second_duration = irpd_pkg::TICK_W'($urandom_range(0, 32767));
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // one input transfer; the frame result, if any, is queued once accepted
    task automatic offer(input irpd_pkg::t_in_item sym, input bit fixed,
                         input irpd_pkg::t_out_item want);
        irpd_pkg::t_out_item res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= sym;
        do @(posedge i_clk); while (!o_in_ready);
        symbols_sent++;
        if (decode_symbol(sym, res))
            frames_due.push_back(fixed ? want : res);
    endtask

    // one frame of random shape: mostly well formed, some short, long or headless,
    // and now and then a few loose symbols
    task automatic send_frame();
        int unsigned pick;
        int unsigned len;
        bit          hdr_good;
        t_sym_kind   kind;
        pick = $urandom_range(0, 99);
        if (pick >= 90) begin
            len = $urandom_range(1, 4);
            repeat (len)
                offer(make_symbol(SYM_JUNK, 1'($urandom_range(0, 1))), 1'b0, NO_FRAME);
            return;
        end
        hdr_good = 1'b1;
        if (pick < 66)
            len = irpd_pkg::FRAME_SYMBOLS;
        else if (pick < 74)
            len = $urandom_range(1, irpd_pkg::FRAME_SYMBOLS - 1);
        else if (pick < 82)
            len = $urandom_range(irpd_pkg::FRAME_SYMBOLS + 1, 72);  // past saturation at times
        else begin
            len      = irpd_pkg::FRAME_SYMBOLS;
            hdr_good = 1'b0;
        end
        for (int unsigned n = 0; n < len; n++) begin
            if (n == 0)
                kind = hdr_good ? SYM_LEADER : ($urandom_range(0, 1) ? SYM_ZERO : SYM_JUNK);
            else if (n > 2 * irpd_pkg::FIELD_BITS)
                kind = SYM_JUNK;   // trailing symbols carry nothing
            else
                kind = $urandom_range(0, 1) ? SYM_ONE : SYM_ZERO;
            offer(make_symbol(kind, n == len - 1), 1'b0, NO_FRAME);
        end
    endtask

    // drop valid and let every owed frame drain, plus the pipeline tail
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input irpd_pkg::t_cfg_reg idx,
                             input logic [irpd_pkg::TICK_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_setting s);
        write_reg(irpd_pkg::REG_INVERT,       irpd_pkg::TICK_W'(s.inv));
        write_reg(irpd_pkg::REG_LEADER_MARK,  s.lead_mark);
        write_reg(irpd_pkg::REG_LEADER_SPACE, s.lead_space);
        write_reg(irpd_pkg::REG_ZERO_MARK,    s.zero_mark);
        write_reg(irpd_pkg::REG_ZERO_SPACE,   s.zero_space);
        write_reg(irpd_pkg::REG_ONE_MARK,     s.one_mark);
        write_reg(irpd_pkg::REG_ONE_SPACE,    s.one_space);
        write_reg(irpd_pkg::REG_TOLERANCE,    s.tol);
        i_cfg_we <= 1'b0;
        cfg_now = s;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: checks each result transfer and drives ready
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        irpd_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t unexpected frame result: status %0d addr %h cmd %h",
                         $time, o_out_data.frame_status, o_out_data.device_address,
                         o_out_data.key_command);
                fault_count++;
            end else begin
                want = frames_due.pop_front();
                if (o_out_data.frame_status !== want.frame_status ||
                    o_out_data.device_address !== want.device_address ||
                    o_out_data.key_command !== want.key_command) begin
                    $display("%0t frame mismatch: expected %0d %h %h, got %0d %h %h",
                             $time, want.frame_status, want.device_address,
                             want.key_command, o_out_data.frame_status,
                             o_out_data.device_address, o_out_data.key_command);
                    fault_count++;
                end
            end
        end
        // long hold-off on request, otherwise random idling
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase_start;
        bit mid_done;
        tx_idle_pct = 9;
        rx_idle_pct <= 51;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset values in force
        foreach (plan[r])
            offer(plan[r].sym, plan[r].fixed, plan[r].want);

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            if (ph > 0) begin
                wait_idle();
                apply_setting(phase_cfg[ph]);
            end
            // sender light / receiver heavy, then swapped, then no idling
            if (ph < 2) begin
                tx_idle_pct = 9;
                rx_idle_pct <= 51;
            end else if (ph < 4) begin
                tx_idle_pct = 51;
                rx_idle_pct <= 9;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            phase_start = symbols_sent;
            mid_done    = 1'b0;
            while (symbols_sent - phase_start < PHASE_SYMBOLS) begin
                // halfway through: receiver stalls long so the input backs up,
                // or the sender stops until every owed frame is out
                if (symbols_sent - phase_start >= PHASE_SYMBOLS / 2 && !mid_done) begin
                    mid_done = 1'b1;
                    if (ph == 0)
                        hold_token <= 1;
                    if (ph == 2)
                        wait_idle();
                end
                send_frame();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/irpd_pkg.sv
rtl/ir_pulse_distance_frame_decoder.sv
tb/ir_pulse_distance_frame_decoder_tb.sv
